[design/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;

	localparam int ElemW     = 16;
	localparam int EstW      = 19;
	localparam int OffW      = 17;
	localparam int VecW      = 19;
	localparam int MagW      = 18;
	localparam int SqW       = 2 * MagW;
	localparam int SumW      = SqW + 2;
	localparam int SqrtShift = 20;
	localparam int RootW     = (SumW + SqrtShift) / 2;
	localparam int RemW      = RootW + 1;
	localparam int DivShift  = 24;
	localparam int DivW      = MagW + DivShift + 1;
	localparam int QuoW      = 17;
	localparam int Lanes     = 4;

	localparam logic [EstW-1:0] EstBias = EstW'(16384);

	localparam logic [1:0] BrS = 2'd0;
	localparam logic [1:0] BrI = 2'd1;
	localparam logic [1:0] BrJ = 2'd2;
	localparam logic [1:0] BrK = 2'd3;

	typedef struct packed {
		logic [Lanes-1:0][MagW-1:0] mag;
		logic [Lanes-1:0]           neg;
		logic [1:0]                 br;
		logic                       degen;
	} side_t;

endpackage
`default_nettype wire

[design/rmq_front.sv]
`default_nettype none
module rmq_front (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     en,
	input  wire                                     in_valid,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_xx,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_xy,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_xz,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_yx,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_yy,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_yz,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_zx,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_zy,
	input  wire signed [rmq_pkg::ElemW-1:0]         elem_zz,
	output logic                                    out_valid,
	output logic [rmq_pkg::SumW-1:0]                sum,
	output rmq_pkg::side_t                          side
);

	localparam int EstW = rmq_pkg::EstW;
	localparam int OffW = rmq_pkg::OffW;
	localparam int VecW = rmq_pkg::VecW;
	localparam int MagW = rmq_pkg::MagW;
	localparam int SqW  = rmq_pkg::SqW;
	localparam int SumW = rmq_pkg::SumW;
	localparam int L    = rmq_pkg::Lanes;

	// stage 1: estimates and off-diagonal terms
	logic signed [EstW-1:0] xx_e, yy_e, zz_e;
	logic vld_s1;
	logic signed [EstW-1:0] es_s1, ei_s1, ej_s1, ek_s1;
	logic signed [OffW-1:0] dz_s1, dy_s1, dx_s1, px_s1, py_s1, pz_s1;

	assign xx_e = EstW'(elem_xx);
	assign yy_e = EstW'(elem_yy);
	assign zz_e = EstW'(elem_zz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			es_s1 <= xx_e + yy_e + zz_e + rmq_pkg::EstBias;
			ei_s1 <= zz_e - xx_e - yy_e + rmq_pkg::EstBias;
			ej_s1 <= yy_e - xx_e - zz_e + rmq_pkg::EstBias;
			ek_s1 <= xx_e - yy_e - zz_e + rmq_pkg::EstBias;
			dz_s1 <= OffW'(elem_yx) - OffW'(elem_xy);
			dy_s1 <= OffW'(elem_xz) - OffW'(elem_zx);
			dx_s1 <= OffW'(elem_zy) - OffW'(elem_yz);
			px_s1 <= OffW'(elem_yz) + OffW'(elem_zy);
			py_s1 <= OffW'(elem_zx) + OffW'(elem_xz);
			pz_s1 <= OffW'(elem_yx) + OffW'(elem_xy);
		end
	end

	// stage 2: pick the branch, build the scaled vector, fix its sign
	logic [1:0] br;
	logic signed [EstW-1:0] e_sel;
	logic signed [VecW-1:0] vec [L];
	logic signed [VecW-1:0] w;
	rmq_pkg::side_t side_c;
	logic vld_s2;
	rmq_pkg::side_t side_s2;

	always_comb begin
		if (es_s1 > ei_s1)
			br = (es_s1 > ej_s1) ? ((es_s1 > ek_s1) ? rmq_pkg::BrS : rmq_pkg::BrK)
			                     : ((ej_s1 > ek_s1) ? rmq_pkg::BrJ : rmq_pkg::BrK);
		else
			br = (ei_s1 > ej_s1) ? ((ei_s1 > ek_s1) ? rmq_pkg::BrI : rmq_pkg::BrK)
			                     : ((ej_s1 > ek_s1) ? rmq_pkg::BrJ : rmq_pkg::BrK);
	end

	always_comb begin
		case (br)
			rmq_pkg::BrS: begin
				e_sel  = es_s1;
				vec[0] = VecW'(es_s1);
				vec[1] = VecW'(dz_s1);
				vec[2] = VecW'(dy_s1);
				vec[3] = VecW'(dx_s1);
			end
			rmq_pkg::BrI: begin
				e_sel  = ei_s1;
				vec[0] = VecW'(dz_s1);
				vec[1] = VecW'(ei_s1);
				vec[2] = VecW'(px_s1);
				vec[3] = VecW'(py_s1);
			end
			rmq_pkg::BrJ: begin
				e_sel  = ej_s1;
				vec[0] = VecW'(dy_s1);
				vec[1] = VecW'(px_s1);
				vec[2] = VecW'(ej_s1);
				vec[3] = VecW'(pz_s1);
			end
			default: begin
				e_sel  = ek_s1;
				vec[0] = VecW'(dx_s1);
				vec[1] = VecW'(py_s1);
				vec[2] = VecW'(pz_s1);
				vec[3] = VecW'(ek_s1);
			end
		endcase
	end

	always_comb begin
		side_c       = '0;
		side_c.br    = br;
		side_c.degen = (e_sel <= 0);
		for (int c = 0; c < L; c++) begin
			w = vec[0][VecW-1] ? -vec[c] : vec[c];
			side_c.neg[c] = w[VecW-1];
			side_c.mag[c] = w[VecW-1] ? MagW'(-w) : MagW'(w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c;
		end
	end

	// stage 3: squares
	logic vld_s3;
	logic [L-1:0][SqW-1:0] sq_s3;
	rmq_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < L; c++)
				sq_s3[c] <= side_s2.mag[c] * side_s2.mag[c];
			side_s3 <= side_s2;
		end
	end

	// stage 4: sum of squares
	logic vld_s4;
	logic [SumW-1:0] sum_s4;
	rmq_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= SumW'(sq_s3[0]) + SumW'(sq_s3[1]) + SumW'(sq_s3[2])
			         + SumW'(sq_s3[3]);
			side_s4 <= side_s3;
		end
	end

	assign out_valid = vld_s4;
	assign sum       = sum_s4;
	assign side      = side_s4;

endmodule
`default_nettype wire

[design/rmq_isqrt.sv]
`default_nettype none
module rmq_isqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_valid,
	input  wire [rmq_pkg::SumW-1:0]      sum,
	input  wire rmq_pkg::side_t          in_side,
	output logic                         out_valid,
	output logic [rmq_pkg::RootW-1:0]    root,
	output rmq_pkg::side_t               out_side
);

	localparam int SumW  = rmq_pkg::SumW;
	localparam int RootW = rmq_pkg::RootW;
	localparam int RemW  = rmq_pkg::RemW;

	// one root bit per stage on sum * 2^20; the low radicand bits are zero
	wire                 vld_w  [RootW+1];
	wire [SumW-1:0]      sum_w  [RootW+1];
	wire [RemW-1:0]      rem_w  [RootW+1];
	wire [RootW-1:0]     root_w [RootW+1];
	rmq_pkg::side_t      side_w [RootW+1];

	assign vld_w[0]  = in_valid;
	assign sum_w[0]  = sum;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign side_w[0] = in_side;

	for (genvar g = 0; g < RootW; g++) begin : g_stage
		localparam int Pos = 2 * (RootW - 1 - g) - rmq_pkg::SqrtShift;
		logic [1:0]          pair;
		logic [RemW+1:0]     cur, trial, diff;
		logic                ge;
		logic                vld_sk;
		logic [SumW-1:0]     sum_sk;
		logic [RemW-1:0]     rem_sk;
		logic [RootW-1:0]    root_sk;
		rmq_pkg::side_t      side_sk;

		if (Pos >= 0) begin : g_bits
			assign pair = sum_w[g][Pos+1:Pos];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign cur   = {rem_w[g], pair};
		assign trial = {{(RemW - RootW){1'b0}}, root_w[g], 2'b01};
		assign ge    = (cur >= trial);
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk <= 1'b0;
			end else if (en) begin
				vld_sk <= vld_w[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
				root_sk <= {root_w[g][RootW-2:0], ge};
				sum_sk  <= sum_w[g];
				side_sk <= side_w[g];
			end
		end

		assign vld_w[g+1]  = vld_sk;
		assign sum_w[g+1]  = sum_sk;
		assign rem_w[g+1]  = rem_sk;
		assign root_w[g+1] = root_sk;
		assign side_w[g+1] = side_sk;
	end

	assign out_valid = vld_w[RootW];
	assign root      = root_w[RootW];
	assign out_side  = side_w[RootW];

endmodule
`default_nettype wire

[design/rmq_div.sv]
`default_nettype none
module rmq_div (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             en,
	input  wire                                             in_valid,
	input  wire [rmq_pkg::RootW-1:0]                        root,
	input  wire rmq_pkg::side_t                             in_side,
	output logic                                            out_valid,
	output logic [rmq_pkg::Lanes-1:0][rmq_pkg::QuoW-1:0]    quo,
	output rmq_pkg::side_t                                  out_side
);

	localparam int RootW = rmq_pkg::RootW;
	localparam int RemW  = rmq_pkg::RemW;
	localparam int DivW  = rmq_pkg::DivW;
	localparam int QuoW  = rmq_pkg::QuoW;
	localparam int L     = rmq_pkg::Lanes;

	// prep: dividend = mag * 2^24 + m/2, top bits seed the remainder
	logic [RootW-1:0] m;
	logic [L-1:0][DivW-1:0] dvd;
	logic vld_p;
	logic [RootW-1:0] m_p;
	logic [L-1:0][RemW-1:0] rem_p;
	logic [L-1:0][QuoW-1:0] low_p;
	rmq_pkg::side_t side_p;

	assign m = (root == '0) ? RootW'(1) : root;

	always_comb begin
		for (int c = 0; c < L; c++)
			dvd[c] = DivW'({in_side.mag[c], {rmq_pkg::DivShift{1'b0}}})
			       + DivW'(m >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else if (en) begin
			vld_p <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_p    <= m;
			side_p <= in_side;
			for (int c = 0; c < L; c++) begin
				rem_p[c] <= RemW'(dvd[c][DivW-1:QuoW]);
				low_p[c] <= dvd[c][QuoW-1:0];
			end
		end
	end

	wire                        vld_w  [QuoW+1];
	wire [RootW-1:0]            m_w    [QuoW+1];
	wire [L-1:0][RemW-1:0]      rem_w  [QuoW+1];
	wire [L-1:0][QuoW-1:0]      low_w  [QuoW+1];
	wire [L-1:0][QuoW-1:0]      quo_w  [QuoW+1];
	rmq_pkg::side_t             side_w [QuoW+1];

	assign vld_w[0]  = vld_p;
	assign m_w[0]    = m_p;
	assign rem_w[0]  = rem_p;
	assign low_w[0]  = low_p;
	assign quo_w[0]  = '0;
	assign side_w[0] = side_p;

	// restoring division, one quotient bit per stage on all four lanes
	for (genvar g = 0; g < QuoW; g++) begin : g_stage
		logic [RemW:0]              cur  [L];
		logic [RemW:0]              diff [L];
		logic [L-1:0]               ge;
		logic                       vld_sk;
		logic [RootW-1:0]           m_sk;
		logic [L-1:0][RemW-1:0]     rem_sk;
		logic [L-1:0][QuoW-1:0]     low_sk;
		logic [L-1:0][QuoW-1:0]     quo_sk;
		rmq_pkg::side_t             side_sk;

		always_comb begin
			for (int c = 0; c < L; c++) begin
				cur[c]  = {rem_w[g][c], low_w[g][c][QuoW-1-g]};
				ge[c]   = (cur[c] >= (RemW+1)'(m_w[g]));
				diff[c] = cur[c] - (RemW+1)'(m_w[g]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk <= 1'b0;
			end else if (en) begin
				vld_sk <= vld_w[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_sk    <= m_w[g];
				low_sk  <= low_w[g];
				side_sk <= side_w[g];
				for (int c = 0; c < L; c++) begin
					rem_sk[c] <= ge[c] ? diff[c][RemW-1:0] : cur[c][RemW-1:0];
					quo_sk[c] <= {quo_w[g][c][QuoW-2:0], ge[c]};
				end
			end
		end

		assign vld_w[g+1]  = vld_sk;
		assign m_w[g+1]    = m_sk;
		assign rem_w[g+1]  = rem_sk;
		assign low_w[g+1]  = low_sk;
		assign quo_w[g+1]  = quo_sk;
		assign side_w[g+1] = side_sk;
	end

	assign out_valid = vld_w[QuoW];
	assign quo       = quo_w[QuoW];
	assign out_side  = side_w[QuoW];

endmodule
`default_nettype wire

[design/rotation_matrix_to_quaternion.sv]
`default_nettype none
// Throughput: one matrix per cycle; the whole pipeline moves on one enable,
// so a stalled output holds every stage and in_stall follows it.
// A beat passes the front end, the 29-stage root pipeline, the four-lane
// divider (prep register, 17 quotient stages) and the output register.
// Reset (arst_n low, asynchronous) empties the pipeline; no results pending.
module rotation_matrix_to_quaternion (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_xx,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_xy,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_xz,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_yx,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_yy,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_yz,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_zx,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_zy,
	input  wire signed [rmq_pkg::ElemW-1:0]  elem_zz,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [rmq_pkg::ElemW-1:0] quat_s,
	output logic signed [rmq_pkg::ElemW-1:0] quat_i,
	output logic signed [rmq_pkg::ElemW-1:0] quat_j,
	output logic signed [rmq_pkg::ElemW-1:0] quat_k,
	output logic [1:0]                       branch_taken,
	output logic                             degenerate
);

	localparam int ElemW = rmq_pkg::ElemW;
	localparam int QuoW  = rmq_pkg::QuoW;
	localparam int L     = rmq_pkg::Lanes;

	logic en;
	logic fr_valid;
	logic [rmq_pkg::SumW-1:0] fr_sum;
	rmq_pkg::side_t fr_side;
	logic sq_valid;
	logic [rmq_pkg::RootW-1:0] sq_root;
	rmq_pkg::side_t sq_side;
	logic dv_valid;
	logic [L-1:0][QuoW-1:0] dv_quo;
	rmq_pkg::side_t dv_side;

	logic vld_q;
	logic signed [ElemW-1:0] res_q [L];
	logic [1:0] br_q;
	logic degen_q;
	logic signed [ElemW-1:0] res_c [L];

	assign en       = !vld_q || !out_stall;
	assign in_stall = !en;

	rmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.elem_xx   (elem_xx),
		.elem_xy   (elem_xy),
		.elem_xz   (elem_xz),
		.elem_yx   (elem_yx),
		.elem_yy   (elem_yy),
		.elem_yz   (elem_yz),
		.elem_zx   (elem_zx),
		.elem_zy   (elem_zy),
		.elem_zz   (elem_zz),
		.out_valid (fr_valid),
		.sum       (fr_sum),
		.side      (fr_side)
	);

	rmq_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.sum       (fr_sum),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	rmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	// sign restore and saturation
	always_comb begin
		for (int c = 0; c < L; c++) begin
			if (dv_side.degen)
				res_c[c] = '0;
			else if (dv_side.neg[c])
				res_c[c] = (dv_quo[c] > QuoW'(32768)) ? ElemW'(-32768)
				                                      : ElemW'(-dv_quo[c]);
			else
				res_c[c] = (dv_quo[c] > QuoW'(32767)) ? ElemW'(32767)
				                                      : ElemW'(dv_quo[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= res_c;
			br_q    <= dv_side.br;
			degen_q <= dv_side.degen;
		end
	end

	assign out_valid    = vld_q;
	assign quat_s       = res_q[0];
	assign quat_i       = res_q[1];
	assign quat_j       = res_q[2];
	assign quat_k       = res_q[3];
	assign branch_taken = br_q;
	assign degenerate   = degen_q;

endmodule
`default_nettype wire
